FILE: design/elp_pkg.sv
// Shared constants and register codes for the adaptive low-pass filter.
`default_nettype none

package elp_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int REG_WIDTH        = 16;
	localparam int REG_IDX_WIDTH    = 2;
	localparam int FRAC_BITS        = 16;
	localparam int ALPHA_FRAC       = 15;

	localparam logic [REG_IDX_WIDTH-1:0] REG_ALPHA_NORMAL   = 2'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_ALPHA_EVENT    = 2'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_DIFF_THRESHOLD = 2'd2;
	localparam logic [REG_IDX_WIDTH-1:0] REG_DECAY_SAMPLES  = 2'd3;

	localparam logic [REG_WIDTH-1:0] ALPHA_NORMAL_RST   = 16'd4096;
	localparam logic [REG_WIDTH-1:0] ALPHA_EVENT_RST    = 16'd16384;
	localparam logic [REG_WIDTH-1:0] DIFF_THRESHOLD_RST = 16'd1000;
	localparam logic [REG_WIDTH-1:0] DECAY_SAMPLES_RST  = 16'd100;

	localparam logic [REG_WIDTH-1:0] ALPHA_ONE = 16'd32768;
	localparam logic [REG_WIDTH-1:0] TIMER_MAX = 16'hFFFF;

	localparam logic CMD_FILTER  = 1'b0;
	localparam logic CMD_TRIGGER = 1'b1;

endpackage

`default_nettype wire

FILE: design/elp_if.sv
// Valid/ready channel interfaces for samples in and filtered results out.
`default_nettype none

interface elp_in_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic                command;
	logic signed [W-1:0] sample;

	modport source (output valid, output command, output sample, input ready);
	modport sink   (input valid, input command, input sample, output ready);
endinterface

interface elp_out_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] filtered;
	logic                in_event;

	modport source (output valid, output filtered, output in_event, input ready);
	modport sink   (input valid, input filtered, input in_event, output ready);
endinterface

`default_nettype wire

FILE: design/event_adaptive_lowpass_filter_core.sv
// Adaptive one-pole low-pass filter: input stage, filter update and result register.
//
// Usage:
//   sample_ch carries transactions of {command, sample}. command = filter runs one
//   filter step and produces one transaction on result_ch {filtered, in_event};
//   command = trigger forces event mode, restarts the decay timer and produces nothing.
//   wr_en/wr_index/wr_data write the four 16-bit registers (alpha_normal,
//   alpha_event, diff_threshold, decay_samples); write only while the block is idle.
// Path: a sample accepted into the input stage has its result loaded into the result
//   register when that stage advances; result_ch can take it from there.
// Throughput: one transaction per cycle unless stalled as below. The filter state
//   feeds back through an alpha-by-difference multiply and add, which sets this rate.
// Stall: while the result register is full and result_ch.ready is low, a filter
//   command waits in the input stage and sample_ch.ready drops; a trigger in the
//   input stage still completes since it needs no result slot.
// Reset: arst_n clears the filter state, event mode, timer, last sample and both
//   stage valids, and loads the register defaults.
`default_nettype none

module event_adaptive_lowpass_filter_core
	import elp_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	elp_in_if.sink                        sample_ch,
	elp_out_if.source                     result_ch,
	input  wire logic                     wr_en,
	input  wire logic [REG_IDX_WIDTH-1:0] wr_index,
	input  wire logic [REG_WIDTH-1:0]     wr_data
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int YW = SW + FRAC_BITS + 1;   // filter state, Q(SW).16 with headroom
	localparam int DW = YW + 1;               // target minus state
	localparam int PW = DW + REG_WIDTH + 1;   // alpha times difference
	localparam int RW = YW + 1 - FRAC_BITS;   // rounded output before saturation

	localparam logic signed [PW-1:0] STEP_RND = PW'(1) <<< (ALPHA_FRAC - 1);
	localparam logic signed [YW:0]   OUT_RND  = (YW + 1)'(1) <<< (FRAC_BITS - 1);

	// configuration
	logic [REG_WIDTH-1:0] alpha_normal_q, alpha_event_q, diff_threshold_q, decay_samples_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_normal_q   <= ALPHA_NORMAL_RST;
			alpha_event_q    <= ALPHA_EVENT_RST;
			diff_threshold_q <= DIFF_THRESHOLD_RST;
			decay_samples_q  <= DECAY_SAMPLES_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ALPHA_NORMAL:   alpha_normal_q   <= wr_data;
				REG_ALPHA_EVENT:    alpha_event_q    <= wr_data;
				REG_DIFF_THRESHOLD: diff_threshold_q <= wr_data;
				REG_DECAY_SAMPLES:  decay_samples_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// input stage
	logic                 valid_s1;
	logic                 cmd_s1;
	logic signed [SW-1:0] sample_s1;
	logic                 out_valid_q;
	logic                 adv_s1;
	logic                 take_in;

	assign adv_s1 = valid_s1 && (cmd_s1 == CMD_TRIGGER || !out_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || adv_s1;
	assign take_in = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1    <= sample_ch.command;
			sample_s1 <= sample_ch.sample;
		end
	end

	// filter state
	logic                 event_q;
	logic [REG_WIDTH-1:0] timer_q;
	logic signed [SW-1:0] last_q;
	logic signed [YW-1:0] y_q;

	// event detection
	logic signed [SW:0]   diff;
	logic [SW:0]          mag;
	logic                 hit;
	logic                 ev0, ev1;
	logic [REG_WIDTH-1:0] tmr0, tmr1;

	assign diff = {sample_s1[SW-1], sample_s1} - {last_q[SW-1], last_q};
	assign mag  = diff[SW] ? -diff : diff;
	assign hit  = ({{REG_WIDTH{1'b0}}, mag} > {{(SW + 1){1'b0}}, diff_threshold_q}) && !event_q;
	assign ev0  = event_q || hit;
	assign tmr0 = hit ? '0 : timer_q;

	always_comb begin
		tmr1 = tmr0;
		ev1  = ev0;
		if (ev0) begin
			if (tmr0 != TIMER_MAX)
				tmr1 = tmr0 + 1'b1;
			if (tmr1 >= decay_samples_q)
				ev1 = 1'b0;
		end
	end

	// filter update
	logic [REG_WIDTH-1:0]    alpha_sel, alpha_c;
	logic signed [REG_WIDTH:0] alpha_s;
	logic signed [DW-1:0]    x_fix, y_ext, d;
	logic signed [PW-1:0]    prod, step;
	logic signed [YW-1:0]    y_next;
	logic signed [YW:0]      y_rnd;
	logic signed [RW-1:0]    r;
	logic signed [SW-1:0]    r_sat;

	assign alpha_sel = ev1 ? alpha_event_q : alpha_normal_q;
	assign alpha_c   = (alpha_sel > ALPHA_ONE) ? ALPHA_ONE : alpha_sel;
	assign alpha_s   = {1'b0, alpha_c};

	assign x_fix  = {{(DW - SW - FRAC_BITS){sample_s1[SW-1]}}, sample_s1, {FRAC_BITS{1'b0}}};
	assign y_ext  = {y_q[YW-1], y_q};
	assign d      = x_fix - y_ext;
	assign prod   = alpha_s * d;
	assign step   = (prod + STEP_RND) >>> ALPHA_FRAC;
	assign y_next = y_q + step[YW-1:0];

	assign y_rnd = ({y_next[YW-1], y_next} + OUT_RND) >>> FRAC_BITS;
	assign r     = y_rnd[RW-1:0];

	always_comb begin
		if (r[RW-1:SW-1] == '0 || r[RW-1:SW-1] == '1)
			r_sat = r[SW-1:0];
		else if (r[RW-1])
			r_sat = {1'b1, {(SW - 1){1'b0}}};
		else
			r_sat = {1'b0, {(SW - 1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_q <= 1'b0;
			timer_q <= '0;
			last_q  <= '0;
			y_q     <= '0;
		end else if (adv_s1) begin
			if (cmd_s1 == CMD_TRIGGER) begin
				event_q <= 1'b1;
				timer_q <= '0;
			end else begin
				event_q <= ev1;
				timer_q <= tmr1;
				last_q  <= sample_s1;
				y_q     <= y_next;
			end
		end
	end

	// result register
	logic signed [SW-1:0] res_filtered_q;
	logic                 res_event_q;
	logic                 load_out;

	assign load_out = adv_s1 && cmd_s1 == CMD_FILTER;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_filtered_q <= r_sat;
			res_event_q    <= ev1;
		end
	end

	assign result_ch.valid    = out_valid_q;
	assign result_ch.filtered = res_filtered_q;
	assign result_ch.in_event = res_event_q;

	// checks
	a_trigger_sets_event: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cmd_s1 == CMD_TRIGGER |=> event_q && timer_q == '0)
		else $error("trigger did not enter event mode with a cleared timer");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(event_q) && $stable(timer_q) && $stable(y_q) && $stable(last_q))
		else $error("filter state changed without a transaction");

	a_result_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && res_event_q == event_q)
		else $error("result event flag differs from event state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cmd_s1 == CMD_FILTER && out_valid_q && !result_ch.ready
		|-> !sample_ch.ready && !adv_s1)
		else $error("pending result would be overwritten");

endmodule

`default_nettype wire

FILE: sim/event_adaptive_lowpass_filter_core_tb.sv
// Self-checking testbench for the adaptive one-pole low-pass filter core.
`timescale 1ns / 1ps

module event_adaptive_lowpass_filter_core_tb
	import elp_pkg::*;
();

	localparam int W           = SAMPLE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 90;
	localparam int SETTLE      = 4;

	typedef struct packed {
		logic [W-1:0] filtered;
		logic         in_event;
	} lpf_result_t;

	// Tracks filter state and register values, predicts one output per filter transaction.
	class smoothing_checker;
		logic [REG_WIDTH-1:0] alpha_norm;
		logic [REG_WIDTH-1:0] alpha_evt;
		logic [REG_WIDTH-1:0] jump_limit;
		logic [REG_WIDTH-1:0] decay_len;
		bit                   evt_mode;
		logic [REG_WIDTH-1:0] decay_cnt;
		logic signed [W-1:0]  prev_sample;
		logic signed [W+16:0] smooth;
		lpf_result_t          pending_outputs[$];
		int                   errors;

		function new();
			alpha_norm  = ALPHA_NORMAL_RST;
			alpha_evt   = ALPHA_EVENT_RST;
			jump_limit  = DIFF_THRESHOLD_RST;
			decay_len   = DECAY_SAMPLES_RST;
			evt_mode    = 1'b0;
			decay_cnt   = '0;
			prev_sample = '0;
			smooth      = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] val);
			case (idx)
				REG_ALPHA_NORMAL:   alpha_norm = val;
				REG_ALPHA_EVENT:    alpha_evt  = val;
				REG_DIFF_THRESHOLD: jump_limit = val;
				REG_DECAY_SAMPLES:  decay_len  = val;
				default: ;
			endcase
		endfunction

		function void take_sample(logic cmd, logic signed [W-1:0] x);
			longint              xl;
			longint              jump;
			longint              alpha_l;
			longint              y;
			longint              prod;
			longint              r;
			logic [REG_WIDTH-1:0] a;
			lpf_result_t         res;
			if (cmd == CMD_TRIGGER) begin
				evt_mode  = 1'b1;
				decay_cnt = '0;
				return;
			end
			xl = x;
			jump = xl - prev_sample;
			if (jump < 0)
				jump = -jump;
			prev_sample = x;
			if (jump > jump_limit && !evt_mode) begin
				evt_mode  = 1'b1;
				decay_cnt = '0;
			end
			if (evt_mode) begin
				if (decay_cnt != TIMER_MAX)
					decay_cnt = decay_cnt + 1'b1;
				if (decay_cnt >= decay_len)
					evt_mode = 1'b0;
			end
			a = evt_mode ? alpha_evt : alpha_norm;
			if (a > ALPHA_ONE)
				a = ALPHA_ONE;
			alpha_l = a;
			y = smooth;
			// Q1.15 times Q16.16 difference, round half up back to Q16.16
			prod = alpha_l * ((xl <<< FRAC_BITS) - y);
			y = y + ((prod + (64'sd1 <<< (ALPHA_FRAC - 1))) >>> ALPHA_FRAC);
			smooth = y[W+16:0];
			r = (y + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			res.filtered = r[W-1:0];
			res.in_event = evt_mode;
			pending_outputs.push_back(res);
		endfunction

		function void compare_output(logic [W-1:0] f, logic ev);
			lpf_result_t want;
			if (pending_outputs.size() == 0) begin
				$error("unexpected output: filtered %0d in_event %0b", $signed(f), ev);
				errors++;
				return;
			end
			want = pending_outputs.pop_front();
			if (f !== want.filtered) begin
				$error("filtered: expected %0d, got %0d", $signed(want.filtered), $signed(f));
				errors++;
			end
			if (ev !== want.in_event) begin
				$error("in_event: expected %0b, got %0b", want.in_event, ev);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_outputs.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     wr_en;
	logic [REG_IDX_WIDTH-1:0] wr_index;
	logic [REG_WIDTH-1:0]     wr_data;
	bit                       tx_calm;
	bit                       rx_calm;
	int                       cycles = 0;
	smoothing_checker         sb;

	elp_in_if  #(.W(W)) sample_ch ();
	elp_out_if #(.W(W)) result_ch ();

	event_adaptive_lowpass_filter_core #(
		.SAMPLE_WIDTH(W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic signed [W-1:0] s);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.command <= cmd;
		sample_ch.sample  <= s;
		do @(posedge clk); while (!sample_ch.ready);
		sb.take_sample(cmd, s);
	endtask

	// Stop sending and let every pending output (and any trailing trigger) finish.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic put_reg(input logic [REG_IDX_WIDTH-1:0] idx, input logic [REG_WIDTH-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		sb.set_reg(idx, val);
	endtask

	function automatic logic signed [W-1:0] next_sample(logic signed [W-1:0] prev,
			logic [REG_WIDTH-1:0] thr);
		int                 sel;
		int                 delta;
		logic signed [31:0] t;
		sel = $urandom_range(0, 9);
		if (sel <= 3) begin
			delta = int'($urandom_range(0, 600)) - 300;
		end else if (sel <= 5) begin
			// land right around the event threshold
			delta = int'(thr) + int'($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 1))
				delta = -delta;
		end else if (sel <= 8) begin
			t = $urandom;
			return t[W-1:0];
		end else begin
			case ($urandom_range(0, 3))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return 16'sh0000;
				default: return 16'shFFFF;
			endcase
		end
		t = prev + delta;
		return t[W-1:0];
	endfunction

	initial begin
		forever begin
			int stall;
			stall = rx_calm ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			sb.compare_output(result_ch.filtered, result_ch.in_event);
		end
	end

	initial begin
		logic [REG_WIDTH-1:0] an;
		logic [REG_WIDTH-1:0] ae;
		logic [REG_WIDTH-1:0] thr;
		logic [REG_WIDTH-1:0] dec;
		logic signed [W-1:0]  last_x;
		logic signed [W-1:0]  x;
		logic                 cmd;
		sb = new();
		tx_calm           <= 1'b0;
		rx_calm           <= 1'b0;
		arst_n            <= 1'b0;
		wr_en             <= 1'b0;
		wr_index          <= REG_ALPHA_NORMAL;
		wr_data           <= '0;
		sample_ch.valid   <= 1'b0;
		sample_ch.command <= CMD_FILTER;
		sample_ch.sample  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass on reset register values
		send_item(CMD_FILTER, 16'sd0);
		send_item(CMD_FILTER, 16'sd1000);   // jump equal to threshold stays normal
		send_item(CMD_FILTER, 16'sd2001);   // one over threshold enters event mode
		send_item(CMD_FILTER, 16'sh7FFF);
		send_item(CMD_FILTER, 16'sh7FFF);
		send_item(CMD_FILTER, 16'sh8000);
		send_item(CMD_FILTER, 16'sh8000);
		send_item(CMD_TRIGGER, 16'sh5A5A); // sample ignored, no output
		send_item(CMD_FILTER, -16'sd1);
		send_item(CMD_FILTER, 16'sd1);
		send_item(CMD_TRIGGER, 16'sh0000);
		send_item(CMD_TRIGGER, 16'shFFFF);
		send_item(CMD_FILTER, 16'sh7FFF);
		send_item(CMD_FILTER, 16'sh8000);
		send_item(CMD_FILTER, 16'sh8001);
		last_x = 16'sh8001;
		drain();

		for (int p = 1; p <= PHASES; p++) begin
			case (p)
				1: begin an = 16'd32768; ae = 16'd32768; thr = 16'd0;     dec = 16'd0;     end
				2: begin an = 16'hFFFF;  ae = 16'd40000; thr = 16'hFFFF;  dec = 16'hFFFF;  end
				3: begin an = 16'd0;     ae = 16'd0;     thr = 16'd100;   dec = 16'd3;     end
				4: begin an = 16'd1;     ae = 16'd32767; thr = 16'd500;   dec = 16'd1;     end
				5: begin an = 16'd4096;  ae = 16'd16384; thr = 16'd1000;  dec = 16'd100;   end
				default: begin
					an  = ($urandom_range(0, 3) == 0) ? REG_WIDTH'($urandom_range(32769, 65535))
							: REG_WIDTH'($urandom_range(0, 32768));
					ae  = ($urandom_range(0, 3) == 0) ? REG_WIDTH'($urandom_range(32769, 65535))
							: REG_WIDTH'($urandom_range(0, 32768));
					thr = ($urandom_range(0, 3) == 0) ? REG_WIDTH'($urandom_range(0, 65535))
							: REG_WIDTH'($urandom_range(0, 3000));
					dec = ($urandom_range(0, 3) == 0) ? REG_WIDTH'($urandom_range(0, 65535))
							: REG_WIDTH'($urandom_range(0, 24));
				end
			endcase
			put_reg(REG_ALPHA_NORMAL, an);
			put_reg(REG_ALPHA_EVENT, ae);
			put_reg(REG_DIFF_THRESHOLD, thr);
			put_reg(REG_DECAY_SAMPLES, dec);
			@(posedge clk);
			wr_en   <= 1'b0;
			tx_calm <= (p % 3 == 0);
			rx_calm <= (p % 4 == 1);

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				cmd = ($urandom_range(0, 15) == 0) ? CMD_TRIGGER : CMD_FILTER;
				if (cmd == CMD_TRIGGER) begin
					x = W'($urandom);
				end else begin
					x = next_sample(last_x, thr);
					last_x = x;
				end
				send_item(cmd, x);
			end
			drain();
		end

		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
